[hw/rtl/srwt_pkg.sv]
// shared types, codes and helpers for the sequenced receive window tracker
// no dependencies
`timescale 1ns / 1ps
package srwt_pkg;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int ACCEPT_DEPTH_DEF  = 16;
  localparam int REORDER_DEPTH_DEF = 16;

  localparam int REG_WINDOW_SIZE  = 0;
  localparam int REG_INITIAL_HB   = 1;

  typedef enum logic [1:0] {
    V_VALID   = 2'd0,
    V_FUTURE  = 2'd1,
    V_INVALID = 2'd2,
    V_NONE    = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    F_RECEIVE  = 2'd0,
    F_REGISTER = 2'd1,
    F_FETCH    = 2'd2,
    F_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    K_HEARTBEAT = 2'd0,
    K_ACK       = 2'd1,
    K_UPDATE    = 2'd2,
    K_OTHER     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PEND,
    S_ACC,
    S_ROB,
    S_FETCH,
    S_FIN
  } state_t;

  typedef struct packed {
    logic append;
    logic remove;
    logic clear;
  } list_ctl_t;

  typedef struct packed {
    logic hit;
    logic past_end;
    logic full;
  } list_stat_t;

  // modulo-256 distance check against expected plus one
  function automatic verdict_t classify(input logic [7:0] expected, input logic [7:0] got,
                                        input logic [7:0] window);
    logic [7:0] nxt;
    logic [7:0] gap;
    nxt = expected + 8'd1;
    gap = got - nxt;
    if (got == nxt) return V_VALID;
    if (gap != 8'd0 && gap < window) return V_FUTURE;
    return V_INVALID;
  endfunction

endpackage

[hw/rtl/srwt_in_if.sv]
// input item channel
// no dependencies
`timescale 1ns / 1ps
interface srwt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  msg_type;
  logic [7:0]  update_id;
  logic [7:0]  heartbeat_id;
  logic [15:0] packet_tag;
  logic [15:0] update_ref;
  modport source(output valid, func, msg_type, update_id, heartbeat_id, packet_tag,
                 update_ref, input ready);
  modport sink(input valid, func, msg_type, update_id, heartbeat_id, packet_tag,
               update_ref, output ready);
endinterface

[hw/rtl/srwt_out_if.sv]
// result item channel
// no dependencies
`timescale 1ns / 1ps
interface srwt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic        handled_here;
  logic        restart_timeout;
  logic        fetch_found;
  logic [15:0] fetch_tag;
  logic [7:0]  assigned_id;
  logic [4:0]  accept_count;
  logic [4:0]  pending_count;
  logic        dropped_full;
  modport source(output valid, verdict, handled_here, restart_timeout, fetch_found,
                 fetch_tag, assigned_id, accept_count, pending_count, dropped_full,
                 input ready);
  modport sink(input valid, verdict, handled_here, restart_timeout, fetch_found,
               fetch_tag, assigned_id, accept_count, pending_count, dropped_full,
               output ready);
endinterface

[hw/rtl/srwt_cfg_if.sv]
// configuration write channel
// no dependencies
`timescale 1ns / 1ps
interface srwt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/srwt_cell.sv]
// one list entry: key and data, loads a new entry or its right neighbor's
// no dependencies
`timescale 1ns / 1ps
module srwt_cell #(
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              load_new,
  input  logic              shift_in,
  input  logic [7:0]        new_key,
  input  logic [DATA_W-1:0] new_data,
  input  logic [7:0]        nb_key,
  input  logic [DATA_W-1:0] nb_data,
  input  logic [7:0]        cmp_key,
  output logic [7:0]        key,
  output logic [DATA_W-1:0] data,
  output logic              match
);
  always_ff @(posedge clk) begin
    if (load_new) begin
      key  <= new_key;
      data <= new_data;
    end else if (shift_in) begin
      key  <= nb_key;
      data <= nb_data;
    end
  end

  assign match = (key == cmp_key);
endmodule

[hw/rtl/srwt_list.sv]
// ordered list as a row of cells with fill count, scan, append, remove and clear
// depends on srwt_pkg and srwt_cell
`timescale 1ns / 1ps
module srwt_list #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 16,
  parameter int SCAN_W = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  srwt_pkg::list_ctl_t          ctl,
  input  logic [7:0]                   key,
  input  logic [DATA_W-1:0]            new_data,
  input  logic [SCAN_W-1:0]            scan,
  output srwt_pkg::list_stat_t         stat,
  output logic [DATA_W-1:0]            scan_data,
  output logic [$clog2(DEPTH+1)-1:0]   used
);
  import srwt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]        keys  [DEPTH];
  logic [DATA_W-1:0] datas [DEPTH];
  logic [DEPTH-1:0]  match;
  logic [IDX_W-1:0]  sidx;

  assign sidx = scan[IDX_W-1:0];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0]        nbk;
      logic [DATA_W-1:0] nbd;
      if (i == DEPTH - 1) begin : g_last
        assign nbk = keys[i];
        assign nbd = datas[i];
      end else begin : g_mid
        assign nbk = keys[i+1];
        assign nbd = datas[i+1];
      end
      srwt_cell #(.DATA_W(DATA_W)) u_cell (
        .clk      (clk),
        .load_new (ctl.append && !stat.full && (used == CNT_W'(i))),
        .shift_in (ctl.remove && (scan <= SCAN_W'(i))),
        .new_key  (key),
        .new_data (new_data),
        .nb_key   (nbk),
        .nb_data  (nbd),
        .cmp_key  (key),
        .key      (keys[i]),
        .data     (datas[i]),
        .match    (match[i])
      );
    end
  endgenerate

  always_comb begin
    stat.full     = (used == CNT_W'(DEPTH));
    stat.past_end = (SCAN_W'(used) <= scan);
    stat.hit      = !stat.past_end && match[sidx];
  end

  assign scan_data = datas[sidx];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      used <= '0;
    end else if (ctl.append && !stat.full) begin
      used <= used + CNT_W'(1);
    end else if (ctl.remove && !stat.past_end) begin
      used <= used - CNT_W'(1);
    end
  end
endmodule

[hw/rtl/sequenced_receive_window_tracker.sv]
// receive sequencer for one peer: heartbeat, register, clear and other items go from execute
// straight to finish; ack, update and fetch items scan a list one entry per cycle (one step per
// entry, one more past the end), and a future update scans the accept list, then the reorder list
// one item at a time, the next is taken once the result is loaded and the sequencer is back in
// idle; output stalls hold the result in the finish state
// synchronous active-high reset clears counts and sequence numbers, list entries need none
`timescale 1ns / 1ps
module sequenced_receive_window_tracker #(
  parameter int PENDING_DEPTH = srwt_pkg::PENDING_DEPTH_DEF,
  parameter int ACCEPT_DEPTH  = srwt_pkg::ACCEPT_DEPTH_DEF,
  parameter int REORDER_DEPTH = srwt_pkg::REORDER_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  srwt_in_if.sink   in_ch,
  srwt_out_if.source out_ch,
  srwt_cfg_if.sink  cfg
);
  import srwt_pkg::*;

  localparam int MAX_D  = (PENDING_DEPTH > ACCEPT_DEPTH)
                          ? ((PENDING_DEPTH > REORDER_DEPTH) ? PENDING_DEPTH : REORDER_DEPTH)
                          : ((ACCEPT_DEPTH > REORDER_DEPTH) ? ACCEPT_DEPTH : REORDER_DEPTH);
  localparam int SCAN_W = $clog2(MAX_D + 1);
  localparam int PC_W   = $clog2(PENDING_DEPTH + 1);
  localparam int AC_W   = $clog2(ACCEPT_DEPTH + 1);
  localparam int RC_W   = $clog2(REORDER_DEPTH + 1);

  state_t state, state_next;

  // config register
  logic [7:0] window_size;

  // sequence state
  logic [7:0] expected_heartbeat;
  logic [7:0] expected_update;
  logic [7:0] local_update_counter;

  // latched item
  logic [1:0]  func;
  logic [1:0]  kind;
  logic [7:0]  uid;
  logic [7:0]  hid;
  logic [15:0] tag;
  logic [15:0] uref;

  // working result
  verdict_t    w_verdict;
  logic        w_handled;
  logic        w_restart;
  logic        w_found;
  logic [15:0] w_ftag;
  logic [7:0]  w_assigned;
  logic        w_dropped;

  logic [SCAN_W-1:0] scan;

  // cell rows
  list_ctl_t  pend_ctl, acc_ctl, rob_ctl;
  list_stat_t pend_stat, acc_stat, rob_stat;
  logic [7:0] pend_key, rob_key;
  logic [15:0] pend_sdata, rob_sdata;
  logic [0:0] acc_sdata;
  logic [PC_W-1:0] pend_used;
  logic [AC_W-1:0] acc_used;
  logic [RC_W-1:0] rob_used;

  logic     in_fire, out_free;
  verdict_t hb_v, upd_v;
  logic [7:0] upd_nxt;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  assign hb_v    = classify(expected_heartbeat, hid, window_size);
  assign upd_v   = classify(expected_update, uid, window_size);
  assign upd_nxt = expected_update + 8'd1;

  // key muxing: pending list sees the new number on register, the ack id on scan
  assign pend_key = (state == S_EXEC) ? (local_update_counter + 8'd1) : uid;
  assign rob_key  = (state == S_FETCH) ? upd_nxt : uid;

  srwt_list #(.DEPTH(PENDING_DEPTH), .DATA_W(16), .SCAN_W(SCAN_W)) u_pend (
    .clk(clk), .rst(rst), .ctl(pend_ctl), .key(pend_key), .new_data(uref),
    .scan(scan), .stat(pend_stat), .scan_data(pend_sdata), .used(pend_used)
  );

  srwt_list #(.DEPTH(ACCEPT_DEPTH), .DATA_W(1), .SCAN_W(SCAN_W)) u_acc (
    .clk(clk), .rst(rst), .ctl(acc_ctl), .key(uid), .new_data(1'b0),
    .scan(scan), .stat(acc_stat), .scan_data(acc_sdata), .used(acc_used)
  );

  srwt_list #(.DEPTH(REORDER_DEPTH), .DATA_W(16), .SCAN_W(SCAN_W)) u_rob (
    .clk(clk), .rst(rst), .ctl(rob_ctl), .key(rob_key), .new_data(tag),
    .scan(scan), .stat(rob_stat), .scan_data(rob_sdata), .used(rob_used)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_EXEC;
      S_EXEC: begin
        priority if (func == F_RECEIVE && kind == K_ACK) state_next = S_PEND;
        else if (func == F_RECEIVE && kind == K_UPDATE) state_next = S_ACC;
        else if (func == F_FETCH) state_next = S_FETCH;
        else state_next = S_FIN;
      end
      S_PEND:  if (pend_stat.past_end || pend_stat.hit) state_next = S_FIN;
      S_ACC: begin
        if (acc_stat.past_end || acc_stat.hit) begin
          state_next = (upd_v == V_FUTURE) ? S_ROB : S_FIN;
        end
      end
      S_ROB:   if (rob_stat.past_end || rob_stat.hit) state_next = S_FIN;
      S_FETCH: if (rob_stat.past_end || rob_stat.hit) state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // list commands
  always_comb begin
    pend_ctl = '0;
    acc_ctl  = '0;
    rob_ctl  = '0;
    unique case (state)
      S_EXEC: begin
        pend_ctl.append = (func == F_REGISTER);
        acc_ctl.clear   = (func == F_CLEAR);
      end
      S_PEND:  pend_ctl.remove = pend_stat.hit;
      S_ACC:   acc_ctl.append  = acc_stat.past_end;
      S_ROB:   rob_ctl.append  = rob_stat.past_end;
      S_FETCH: rob_ctl.remove  = rob_stat.hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // config and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size          <= 8'd8;
      expected_heartbeat   <= 8'd0;
      expected_update      <= 8'd0;
      local_update_counter <= 8'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == 8'(REG_WINDOW_SIZE)) window_size <= cfg.data;
        // the initial heartbeat number only seeds the expected heartbeat
        if (cfg.index == 8'(REG_INITIAL_HB)) expected_heartbeat <= cfg.data;
      end
      if (state == S_EXEC) begin
        if (func == F_RECEIVE && kind == K_HEARTBEAT &&
            (hb_v == V_VALID || hb_v == V_FUTURE)) begin
          expected_heartbeat <= expected_heartbeat + 8'd1;
        end
        if (func == F_REGISTER) local_update_counter <= local_update_counter + 8'd1;
      end
      if (state == S_ACC && (acc_stat.past_end || acc_stat.hit) && upd_v == V_VALID) begin
        expected_update <= upd_nxt;
      end
      if (state == S_FETCH && rob_stat.hit) expected_update <= upd_nxt;
    end
  end

  // item latch, scan counter and working result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func <= in_ch.func;
      kind <= in_ch.msg_type;
      uid  <= in_ch.update_id;
      hid  <= in_ch.heartbeat_id;
      tag  <= in_ch.packet_tag;
      uref <= in_ch.update_ref;
    end
    unique case (state)
      S_EXEC: begin
        scan       <= '0;
        w_verdict  <= V_NONE;
        w_handled  <= 1'b0;
        w_restart  <= (func == F_RECEIVE);
        w_found    <= 1'b0;
        w_ftag     <= 16'd0;
        w_assigned <= 8'd0;
        w_dropped  <= 1'b0;
        if (func == F_RECEIVE && kind == K_HEARTBEAT) begin
          w_verdict <= hb_v;
          w_handled <= 1'b1;
          w_restart <= (hb_v == V_VALID || hb_v == V_FUTURE);
        end
        if (func == F_RECEIVE && kind == K_ACK) w_handled <= 1'b1;
        if (func == F_REGISTER) begin
          w_assigned <= local_update_counter + 8'd1;
          w_dropped  <= pend_stat.full;
        end
      end
      S_PEND: scan <= scan + SCAN_W'(1);
      S_ACC: begin
        if (acc_stat.past_end || acc_stat.hit) begin
          // absent id goes to the accept list, then the window check
          if (acc_stat.past_end && acc_stat.full) w_dropped <= 1'b1;
          w_verdict <= upd_v;
          w_handled <= (upd_v != V_VALID);
          scan      <= '0;
        end else begin
          scan <= scan + SCAN_W'(1);
        end
      end
      S_ROB: begin
        if (rob_stat.past_end && rob_stat.full) w_dropped <= 1'b1;
        scan <= scan + SCAN_W'(1);
      end
      S_FETCH: begin
        if (rob_stat.hit) begin
          w_found <= 1'b1;
          w_ftag  <= rob_sdata;
        end
        scan <= scan + SCAN_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_ch.verdict         <= w_verdict;
      out_ch.handled_here    <= w_handled;
      out_ch.restart_timeout <= w_restart;
      out_ch.fetch_found     <= w_found;
      out_ch.fetch_tag       <= w_ftag;
      out_ch.assigned_id     <= w_assigned;
      out_ch.accept_count    <= 5'(acc_used);
      out_ch.pending_count   <= 5'(pend_used);
      out_ch.dropped_full    <= w_dropped;
    end
  end

`ifndef SYNTH
  // an item is only taken in idle and always starts execution
  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_EXEC) else $error("item not executed");
  // the reorder list never appends and removes in the same cycle
  a_rob_ops: assert property (@(posedge clk) disable iff (rst)
    !(rob_ctl.append && rob_ctl.remove)) else $error("reorder append with remove");
  // fill counts stay within their depths
  a_counts: assert property (@(posedge clk) disable iff (rst)
    acc_used <= AC_W'(ACCEPT_DEPTH) && pend_used <= PC_W'(PENDING_DEPTH) &&
    rob_used <= RC_W'(REORDER_DEPTH)) else $error("list count overflow");
`endif
endmodule
